>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, prop, msg)

`define ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

>>> design/dmbm_pkg.sv
// ----------------------------------------------------------------------------
// dmbm_pkg
// Register indexes, opcodes, field widths and reset values of the block mean.
// ----------------------------------------------------------------------------
package dmbm_pkg;

	localparam int CFG_IDX_BITS    = 2;
	localparam int CFG_DATA_BITS   = 16;
	localparam int SKIP_BITS       = 16;
	localparam int LOG2_BITS       = 4;
	localparam int NCH_BITS        = 7;
	localparam int KEPT_BITS       = 16;
	localparam int BLOCK_BITS      = 32;
	localparam int CHAN_FIELD_BITS = 6;

	localparam logic [SKIP_BITS-1:0] SKIP_FRAMES_RST  = 16'd125;
	localparam logic [LOG2_BITS-1:0] LOG2_COUNT_RST   = 4'd4;
	localparam logic [NCH_BITS-1:0]  NUM_CHANNELS_RST = 7'd32;
	localparam logic                 RUN_ENABLE_RST   = 1'b1;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_SKIP_FRAMES  = 2'd0,
		CFG_LOG2_COUNT   = 2'd1,
		CFG_NUM_CHANNELS = 2'd2,
		CFG_RUN_ENABLE   = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_READ   = 1'b1
	} opcode_t;

endpackage

>>> design/dmbm_outbuf.sv
// ----------------------------------------------------------------------------
// dmbm_outbuf
// Two-entry result queue that decouples the sum pipeline from the output.
// ----------------------------------------------------------------------------
module dmbm_outbuf #(
	parameter int WIDTH = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             valid,
	input  logic             ready,
	output logic [WIDTH-1:0] data,
	output logic [1:0]       level
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       level_q;
	logic             pop;

	assign valid = level_q != 2'd0;
	assign pop   = valid && ready;
	assign data  = slot_q[rd_ptr_q];
	assign level = level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			level_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			level_q <= level_q + 2'(push) - 2'(pop);
		end
	end

endmodule

>>> design/decimating_multichannel_block_mean_top.sv
// ----------------------------------------------------------------------------
// decimating_multichannel_block_mean_top
// Takes one item per clock, samples and reads alike. A kept sample reads its
// channel's running sum from the sum memory, adds and writes back in the next
// cycle, with the last written value forwarded when the next item hits the
// same entry, so a frame of any length streams without a stall. Working and
// latched sums share one memory as two banks: closing a block swaps the banks
// and marks the new working bank empty through per-entry valid flags, so no
// copy or clearing sweep ever holds off intake. A read answers through a
// two-entry result queue; in_ready drops only while that queue and the read
// in flight fill it and nothing leaves.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module decimating_multichannel_block_mean_top #(
	parameter int MAX_CHANNELS = 64,
	parameter int SAMPLE_BITS  = 16,
	parameter int SUM_BITS     = 32
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         cfg_wr_en,
	input  logic [dmbm_pkg::CFG_IDX_BITS-1:0]            cfg_index,
	input  logic [dmbm_pkg::CFG_DATA_BITS-1:0]           cfg_wdata,
	input  logic                                         in_valid,
	output logic                                         in_ready,
	input  logic                                         opcode,
	input  logic signed [SAMPLE_BITS-1:0]                sample_value,
	input  logic [dmbm_pkg::CHAN_FIELD_BITS-1:0]         read_channel,
	output logic                                         out_valid,
	input  logic                                         out_ready,
	output logic signed [SAMPLE_BITS-1:0]                mean_value,
	output logic [dmbm_pkg::BLOCK_BITS-1:0]              blocks_done
);

	localparam int CH_BITS   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int ADDR_BITS = CH_BITS + 1;
	localparam int MEM_DEPTH = 2 ** ADDR_BITS;
	localparam int BANK_SIZE = 2 ** CH_BITS;
	localparam int EXT_BITS  = (SUM_BITS > SAMPLE_BITS) ? SUM_BITS : SAMPLE_BITS;
	localparam int LEN_BITS  = ((CH_BITS > dmbm_pkg::NCH_BITS) ? CH_BITS
		: dmbm_pkg::NCH_BITS) + 1;
	localparam int IDX_BITS  = ((CH_BITS > dmbm_pkg::CHAN_FIELD_BITS) ? CH_BITS
		: dmbm_pkg::CHAN_FIELD_BITS) + 1;
	localparam int RES_BITS  = SAMPLE_BITS + dmbm_pkg::BLOCK_BITS;

	// configuration
	logic [dmbm_pkg::SKIP_BITS-1:0]  skip_frames_q;
	logic [dmbm_pkg::LOG2_BITS-1:0]  log2_count_q;
	logic [dmbm_pkg::NCH_BITS-1:0]   num_channels_q;
	logic                            run_enable_q;

	// frame and block control
	logic [dmbm_pkg::SKIP_BITS-1:0]  skip_q;
	logic [dmbm_pkg::KEPT_BITS-1:0]  kept_q;
	logic [CH_BITS-1:0]              pos_q;
	logic                            frame_kept_q;
	logic [dmbm_pkg::BLOCK_BITS-1:0] block_cnt_q;
	logic                            bank_q;
	logic [MEM_DEPTH-1:0]            vld_q;

	logic                            in_acc;
	logic                            is_smp;
	logic                            is_rd;
	logic                            clr_all;
	logic [LEN_BITS-1:0]             pos_nxt;
	logic                            frame_first;
	logic                            frame_last;
	logic [dmbm_pkg::SKIP_BITS:0]    skip_nxt;
	logic                            keep_frame;
	logic                            kept_now;
	logic [dmbm_pkg::KEPT_BITS:0]    kept_nxt;
	logic                            blk_due;
	logic                            blk_done;
	logic                            mem_rd_en;
	logic [ADDR_BITS-1:0]            rd_addr;
	logic                            rd_in_range;
	logic signed [EXT_BITS-1:0]      smp_ext;

	// sum memory
	logic [SUM_BITS-1:0]             mem [MEM_DEPTH];

	// stage 1
	logic                            smp_s1;
	logic                            rd_s1;
	logic                            fwd_s1;
	logic                            vld_s1;
	logic                            inrange_s1;
	logic [ADDR_BITS-1:0]            addr_s1;
	logic [SUM_BITS-1:0]             rdata_s1;
	logic [SUM_BITS-1:0]             smp_s1_val;
	logic [dmbm_pkg::BLOCK_BITS-1:0] blocks_s1;
	logic [SUM_BITS-1:0]             wb_data_q;

	logic [SUM_BITS-1:0]             base_sum;
	logic [SUM_BITS-1:0]             new_sum;
	logic [SUM_BITS-1:0]             rd_sum;
	logic signed [EXT_BITS-1:0]      rd_ext;
	logic signed [EXT_BITS-1:0]      rd_shift;
	logic [SAMPLE_BITS-1:0]          mean_s1;

	// result queue
	logic [RES_BITS-1:0]             q_data;
	logic [1:0]                      q_level;
	logic [1:0]                      used_slots;
	logic                            out_pop;

	assign in_acc  = in_valid && in_ready;
	assign is_smp  = in_acc && (dmbm_pkg::opcode_t'(opcode) == dmbm_pkg::OP_SAMPLE)
		&& run_enable_q;
	assign is_rd   = in_acc && (dmbm_pkg::opcode_t'(opcode) == dmbm_pkg::OP_READ);
	assign clr_all = cfg_wr_en
		&& (dmbm_pkg::cfg_idx_t'(cfg_index) == dmbm_pkg::CFG_RUN_ENABLE) && cfg_wdata[0];

	assign pos_nxt     = LEN_BITS'(pos_q) + LEN_BITS'(1);
	assign frame_first = pos_q == '0;
	assign frame_last  = (pos_nxt >= LEN_BITS'(num_channels_q))
		|| (pos_nxt >= LEN_BITS'(MAX_CHANNELS));
	assign skip_nxt    = {1'b0, skip_q} + 17'd1;
	assign keep_frame  = skip_nxt >= {1'b0, skip_frames_q};
	assign kept_now    = frame_first ? keep_frame : frame_kept_q;
	assign kept_nxt    = {1'b0, kept_q} + 17'd1;
	assign blk_due     = kept_nxt >= (17'd1 << log2_count_q);
	assign blk_done    = is_smp && frame_last && kept_now && blk_due;

	assign rd_in_range = IDX_BITS'(read_channel) < IDX_BITS'(MAX_CHANNELS);
	assign rd_addr     = is_rd ? {~bank_q, CH_BITS'(read_channel)} : {bank_q, pos_q};
	assign mem_rd_en   = is_rd || (is_smp && kept_now);
	assign smp_ext     = EXT_BITS'(sample_value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_frames_q  <= dmbm_pkg::SKIP_FRAMES_RST;
			log2_count_q   <= dmbm_pkg::LOG2_COUNT_RST;
			num_channels_q <= dmbm_pkg::NUM_CHANNELS_RST;
			run_enable_q   <= dmbm_pkg::RUN_ENABLE_RST;
		end else if (cfg_wr_en) begin
			case (dmbm_pkg::cfg_idx_t'(cfg_index))
				dmbm_pkg::CFG_SKIP_FRAMES:  skip_frames_q  <= cfg_wdata[dmbm_pkg::SKIP_BITS-1:0];
				dmbm_pkg::CFG_LOG2_COUNT:   log2_count_q   <= cfg_wdata[dmbm_pkg::LOG2_BITS-1:0];
				dmbm_pkg::CFG_NUM_CHANNELS: num_channels_q <= cfg_wdata[dmbm_pkg::NCH_BITS-1:0];
				dmbm_pkg::CFG_RUN_ENABLE:   run_enable_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q       <= '0;
			kept_q       <= '0;
			pos_q        <= '0;
			frame_kept_q <= 1'b0;
			block_cnt_q  <= '0;
		end else if (clr_all) begin
			skip_q       <= '0;
			kept_q       <= '0;
			pos_q        <= '0;
			frame_kept_q <= 1'b0;
			block_cnt_q  <= '0;
		end else if (is_smp) begin
			if (frame_first) begin
				frame_kept_q <= keep_frame;
				skip_q       <= keep_frame ? '0 : skip_nxt[dmbm_pkg::SKIP_BITS-1:0];
			end
			pos_q <= frame_last ? '0 : pos_nxt[CH_BITS-1:0];
			if (frame_last && kept_now) begin
				if (blk_due) begin
					kept_q      <= '0;
					block_cnt_q <= block_cnt_q + dmbm_pkg::BLOCK_BITS'(1);
				end else begin
					kept_q <= kept_nxt[dmbm_pkg::KEPT_BITS-1:0];
				end
			end
		end
	end

	// swap working and latched banks; empty the new working bank; mark written entries valid, clear all on restart
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= 1'b0;
			vld_q  <= '0;
		end else begin
			if (blk_done) begin
				bank_q <= ~bank_q;
			end
			if (clr_all) begin
				vld_q <= '0;
			end else begin
				if (smp_s1) begin
					vld_q[addr_s1] <= 1'b1;
				end
				for (int i = 0; i < MEM_DEPTH; i++) begin
					if (blk_done && ((i >= BANK_SIZE) != bank_q)) begin
						vld_q[i] <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (smp_s1) begin
			mem[addr_s1] <= new_sum;
		end
		if (mem_rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_s1 <= 1'b0;
			rd_s1  <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			smp_s1 <= is_smp && kept_now;
			rd_s1  <= is_rd;
			fwd_s1 <= smp_s1 && (addr_s1 == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_rd_en) begin
			addr_s1    <= rd_addr;
			vld_s1     <= vld_q[rd_addr];
			inrange_s1 <= rd_in_range;
			smp_s1_val <= smp_ext[SUM_BITS-1:0];
			blocks_s1  <= block_cnt_q;
		end
		if (smp_s1) begin
			wb_data_q <= new_sum;
		end
	end

	assign base_sum = fwd_s1 ? wb_data_q : (vld_s1 ? rdata_s1 : '0);
	assign new_sum  = base_sum + smp_s1_val;
	assign rd_sum   = inrange_s1 ? base_sum : '0;
	assign rd_ext   = EXT_BITS'($signed(rd_sum));
	assign rd_shift = rd_ext >>> log2_count_q;
	assign mean_s1  = rd_shift[SAMPLE_BITS-1:0];

	dmbm_outbuf #(
		.WIDTH(RES_BITS)
	) u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (rd_s1),
		.push_data({mean_s1, blocks_s1}),
		.valid    (out_valid),
		.ready    (out_ready),
		.data     (q_data),
		.level    (q_level)
	);

	assign mean_value  = q_data[RES_BITS-1:dmbm_pkg::BLOCK_BITS];
	assign blocks_done = q_data[dmbm_pkg::BLOCK_BITS-1:0];

	assign out_pop    = out_valid && out_ready;
	assign used_slots = q_level + 2'(rd_s1);
	assign in_ready   = (used_slots != 2'd2) || out_pop;

	`ASSERT_NEVER(a_queue_overrun, (q_level == 2'd2) && rd_s1 && !out_pop, "result queue overrun")
	`ASSERT_ALWAYS(a_pos_bound, LEN_BITS'(pos_q) < LEN_BITS'(MAX_CHANNELS), "position out of range")
	`ASSERT_ALWAYS(a_bank_swap, blk_done |=> (bank_q != $past(bank_q)), "bank did not swap")
	`ASSERT_ALWAYS(a_fwd_source, fwd_s1 |-> $past(smp_s1), "forward without a prior write")

endmodule

>>> bench/tb_decimating_multichannel_block_mean_top.sv
// ----------------------------------------------------------------------------
// tb_decimating_multichannel_block_mean_top
// Self-checking bench for the decimating block mean. A short table of
// directed items runs first. Phases follow, two with fixed corner settings
// and the rest with random register writes, each with a random stream of
// samples and channel reads. Every read transfer is scored against the
// table's value or a local model of the sum banks and counters. The sender
// works in random bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_decimating_multichannel_block_mean_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CH_MAX       = 64;
	localparam int DRAIN_CYCLES = 8;
	localparam int ITEM_TARGET  = 1450;

	typedef struct {
		logic signed [15:0] mean;
		logic [31:0]        blocks;
	} mean_result_t;

	typedef struct {
		bit                 is_reg;
		dmbm_pkg::cfg_idx_t idx;
		logic [15:0]        wdata;
		dmbm_pkg::opcode_t  op;
		logic signed [15:0] smp;
		logic [5:0]         ch;
		bit                 typed;
		mean_result_t       res;
	} stim_row_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               cfg_wr_en    = 1'b0;
	logic [1:0]         cfg_index    = '0;
	logic [15:0]        cfg_wdata    = '0;
	logic               in_valid     = 1'b0;
	logic               in_ready;
	logic               opcode       = 1'b0;
	logic signed [15:0] sample_value = '0;
	logic [5:0]         read_channel = '0;
	logic               out_valid;
	logic               out_ready    = 1'b0;
	logic signed [15:0] mean_value;
	logic [31:0]        blocks_done;

	decimating_multichannel_block_mean_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.sample_value (sample_value),
		.read_channel (read_channel),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.mean_value   (mean_value),
		.blocks_done  (blocks_done)
	);

	always #4 clk = ~clk;

	// model state
	logic [15:0] skip_q;
	logic [3:0]  log2_q;
	logic [6:0]  nch_q;
	logic        en_q;
	logic [31:0] work_sum [CH_MAX];
	logic [31:0] held_sum [CH_MAX];
	int unsigned skip_cnt;
	int unsigned kept_cnt;
	int unsigned chan_pos;
	bit          frame_keep;
	logic [31:0] block_cnt;

	mean_result_t expected_means[$];
	mean_result_t head;
	mean_result_t no_result;
	stim_row_t    directed_rows[$];
	int           fail_count = 0;
	int           burst_left = 0;
	int           rx_mode    = 0;
	int           rx_left    = 0;
	logic [1:0]   rx_tick    = '0;

	function automatic void clear_banks();
		for (int i = 0; i < CH_MAX; i++) begin
			work_sum[i] = '0;
			held_sum[i] = '0;
		end
		skip_cnt   = 0;
		kept_cnt   = 0;
		chan_pos   = 0;
		frame_keep = 1'b0;
		block_cnt  = '0;
	endfunction

	function automatic void apply_reg(dmbm_pkg::cfg_idx_t idx, logic [15:0] v);
		case (idx)
			dmbm_pkg::CFG_SKIP_FRAMES: skip_q = v;
			dmbm_pkg::CFG_LOG2_COUNT: log2_q = v[3:0];
			dmbm_pkg::CFG_NUM_CHANNELS: nch_q = v[6:0];
			default: begin
				en_q = v[0];
				if (v[0])
					clear_banks();
			end
		endcase
	endfunction

	function automatic void accumulate_sample(logic signed [15:0] smp);
		int unsigned n;
		if (nch_q == 0)
			n = 1;
		else if (nch_q > CH_MAX)
			n = CH_MAX;
		else
			n = nch_q;
		if (chan_pos == 0) begin
			if (skip_cnt + 1 >= skip_q) begin
				frame_keep = 1'b1;
				skip_cnt   = 0;
			end else begin
				frame_keep = 1'b0;
				skip_cnt   = skip_cnt + 1;
			end
		end
		if (frame_keep && chan_pos < CH_MAX)
			work_sum[chan_pos] = work_sum[chan_pos] + {{16{smp[15]}}, smp};
		chan_pos++;
		if (chan_pos >= n) begin
			chan_pos = 0;
			if (frame_keep) begin
				kept_cnt = (kept_cnt + 1) & 32'hFFFF;
				if (kept_cnt >= (32'd1 << log2_q)) begin
					held_sum = work_sum;
					for (int i = 0; i < CH_MAX; i++)
						work_sum[i] = '0;
					kept_cnt  = 0;
					block_cnt = block_cnt + 1;
				end
			end
		end
	endfunction

	function automatic mean_result_t channel_mean(logic [5:0] ch);
		mean_result_t     r;
		logic signed [31:0] v;
		v        = held_sum[ch];
		v        = v >>> log2_q;
		r.mean   = v[15:0];
		r.blocks = block_cnt;
		return r;
	endfunction

	// stimulus table builders
	function automatic stim_row_t blank_row();
		stim_row_t r;
		r.is_reg     = 1'b0;
		r.idx        = dmbm_pkg::CFG_SKIP_FRAMES;
		r.wdata      = '0;
		r.op         = dmbm_pkg::OP_SAMPLE;
		r.smp        = '0;
		r.ch         = '0;
		r.typed      = 1'b0;
		r.res.mean   = '0;
		r.res.blocks = '0;
		return r;
	endfunction

	function automatic void add_reg(dmbm_pkg::cfg_idx_t idx, logic [15:0] v);
		stim_row_t r;
		r        = blank_row();
		r.is_reg = 1'b1;
		r.idx    = idx;
		r.wdata  = v;
		directed_rows.push_back(r);
	endfunction

	function automatic void add_sample(logic signed [15:0] v);
		stim_row_t r;
		r     = blank_row();
		r.op  = dmbm_pkg::OP_SAMPLE;
		r.smp = v;
		directed_rows.push_back(r);
	endfunction

	function automatic void add_read(logic [5:0] ch, bit typed, logic signed [15:0] m,
			logic [31:0] b);
		stim_row_t r;
		r            = blank_row();
		r.op         = dmbm_pkg::OP_READ;
		r.ch         = ch;
		r.typed      = typed;
		r.res.mean   = m;
		r.res.blocks = b;
		directed_rows.push_back(r);
	endfunction

	// drain the block before touching a register
	task automatic settle();
		in_valid   <= 1'b0;
		burst_left = 0;
		while (expected_means.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(dmbm_pkg::cfg_idx_t idx, logic [15:0] v);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		apply_reg(idx, v);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_item(dmbm_pkg::opcode_t op, logic signed [15:0] smp, logic [5:0] ch,
			bit typed, mean_result_t typed_res);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 24);
		end
		in_valid     <= 1'b1;
		opcode       <= op;
		sample_value <= smp;
		read_channel <= ch;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		burst_left--;
		if (op == dmbm_pkg::OP_READ)
			expected_means.push_back(typed ? typed_res : channel_mean(ch));
		else if (en_q)
			accumulate_sample(smp);
		@(negedge clk);
	endtask

	// receiver stall pattern
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_left = $urandom_range(16, 160);
		end
		rx_left--;
		rx_tick <= rx_tick + 2'd1;
		case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 2) != 0);
			default: out_ready <= (rx_tick == 2'd0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_means.size() == 0) begin
				$display("%0t: unexpected transfer: mean %0d blocks %0d",
					$time, mean_value, blocks_done);
				fail_count++;
			end else begin
				head = expected_means.pop_front();
				if (mean_value !== head.mean) begin
					$display("%0t: mean_value expected %0d actual %0d",
						$time, head.mean, mean_value);
					fail_count++;
				end
				if (blocks_done !== head.blocks) begin
					$display("%0t: blocks_done expected %0d actual %0d",
						$time, head.blocks, blocks_done);
					fail_count++;
				end
			end
		end
	end

	initial begin : stimulus
		int                counted;
		int                phase;
		int                n_items;
		dmbm_pkg::opcode_t op;
		logic [15:0]       smp;
		logic [15:0]       v;

		counted   = 0;
		no_result = '{default: '0};
		skip_q    = dmbm_pkg::SKIP_FRAMES_RST;
		log2_q    = dmbm_pkg::LOG2_COUNT_RST;
		nch_q     = dmbm_pkg::NUM_CHANNELS_RST;
		en_q      = dmbm_pkg::RUN_ENABLE_RST;
		clear_banks();

		add_read(6'd0, 1'b1, 16'sd0, 32'd0);
		add_read(6'd63, 1'b1, 16'sd0, 32'd0);
		add_reg(dmbm_pkg::CFG_SKIP_FRAMES, 16'd0);
		add_reg(dmbm_pkg::CFG_LOG2_COUNT, 16'd0);
		add_reg(dmbm_pkg::CFG_NUM_CHANNELS, 16'd2);
		add_reg(dmbm_pkg::CFG_RUN_ENABLE, 16'd1);
		add_sample(16'sh7FFF);
		add_sample(16'sh8000);
		add_read(6'd0, 1'b1, 16'sh7FFF, 32'd1);
		add_read(6'd1, 1'b1, 16'sh8000, 32'd1);
		add_read(6'd2, 1'b1, 16'sd0, 32'd1);
		add_reg(dmbm_pkg::CFG_LOG2_COUNT, 16'd1);
		add_sample(-16'sd1);
		add_sample(16'sd1);
		add_sample(16'sh8000);
		add_sample(16'sh7FFF);
		add_read(6'd0, 1'b0, '0, '0);
		add_read(6'd1, 1'b0, '0, '0);
		add_reg(dmbm_pkg::CFG_RUN_ENABLE, 16'd0);
		add_sample(16'sd1000);
		add_read(6'd0, 1'b0, '0, '0);
		add_reg(dmbm_pkg::CFG_NUM_CHANNELS, 16'd0);
		add_reg(dmbm_pkg::CFG_RUN_ENABLE, 16'd1);
		add_read(6'd5, 1'b1, 16'sd0, 32'd0);
		add_sample(16'sd100);
		add_sample(-16'sd7);
		add_read(6'd0, 1'b0, '0, '0);

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_reg) begin
				write_reg(directed_rows[i].idx, directed_rows[i].wdata);
			end else begin
				counted++;
				send_item(directed_rows[i].op, directed_rows[i].smp, directed_rows[i].ch,
					directed_rows[i].typed, directed_rows[i].res);
			end
		end

		phase = 0;
		while (counted < ITEM_TARGET) begin
			if (phase == 0) begin
				write_reg(dmbm_pkg::CFG_SKIP_FRAMES, 16'd65535);
				write_reg(dmbm_pkg::CFG_LOG2_COUNT, 16'd15);
				write_reg(dmbm_pkg::CFG_NUM_CHANNELS, 16'd127);
				write_reg(dmbm_pkg::CFG_RUN_ENABLE, 16'd1);
			end else if (phase == 1) begin
				write_reg(dmbm_pkg::CFG_SKIP_FRAMES, 16'd1);
				write_reg(dmbm_pkg::CFG_LOG2_COUNT, 16'd0);
				write_reg(dmbm_pkg::CFG_NUM_CHANNELS, 16'd64);
				write_reg(dmbm_pkg::CFG_RUN_ENABLE, 16'd1);
			end else begin
				if ($urandom_range(0, 3) != 0) begin
					case ($urandom_range(0, 9))
						0: v = 16'd0;
						1: v = 16'd65535;
						default: v = 16'($urandom_range(1, 4));
					endcase
					write_reg(dmbm_pkg::CFG_SKIP_FRAMES, v);
				end
				if ($urandom_range(0, 3) != 0) begin
					case ($urandom_range(0, 9))
						0: v = 16'd15;
						1: v = 16'($urandom_range(4, 14));
						default: v = 16'($urandom_range(0, 2));
					endcase
					write_reg(dmbm_pkg::CFG_LOG2_COUNT, v);
				end
				if ($urandom_range(0, 3) != 0) begin
					case ($urandom_range(0, 9))
						0: v = 16'd0;
						1: v = 16'd64;
						2: v = 16'd127;
						3: v = 16'($urandom_range(0, 127));
						default: v = 16'($urandom_range(1, 8));
					endcase
					write_reg(dmbm_pkg::CFG_NUM_CHANNELS, v);
				end
				case ($urandom_range(0, 7))
					0: write_reg(dmbm_pkg::CFG_RUN_ENABLE, 16'd0);
					1, 2, 3: write_reg(dmbm_pkg::CFG_RUN_ENABLE, 16'd1);
					default: ;
				endcase
			end
			n_items = $urandom_range(60, 160);
			for (int i = 0; i < n_items && counted < ITEM_TARGET; i++) begin
				op = ($urandom_range(0, 99) < 15) ? dmbm_pkg::OP_READ : dmbm_pkg::OP_SAMPLE;
				case ($urandom_range(0, 15))
					0: smp = 16'h7FFF;
					1: smp = 16'h8000;
					default: smp = 16'($urandom);
				endcase
				counted++;
				send_item(op, smp, 6'($urandom_range(0, 63)), 1'b0, no_result);
			end
			phase++;
		end

		settle();
		if (fail_count == 0)
			$display("decimating_multichannel_block_mean_top regression: pass");
		else
			$display("decimating_multichannel_block_mean_top regression: fail");
		$finish;
	end

	initial begin : watchdog
		#4000000;
		$display("decimating_multichannel_block_mean_top regression: fail");
		$finish;
	end

endmodule
